// ----- hdl/wap_pkg.sv -----
// wap_pkg: shared types and constants for the word alu with power
// no dependencies
`timescale 1ns / 1ps

package wap_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int OP_BITS       = 4;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_REM = 4'd4,
        OP_POW = 4'd5,
        OP_XOR = 4'd6,
        OP_AND = 4'd7,
        OP_OR  = 4'd8,
        OP_NOT = 4'd9
    } t_op;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_DIV0 = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SERIAL,
        S_DIV,
        S_MUL,
        S_POW_CHK,
        S_POW_MUL,
        S_POW_SQR,
        S_DONE
    } t_state;

endpackage

// ----- hdl/wap_ifs.sv -----
// wap_req_if and wap_rsp_if: valid/ready channels of the word alu
// depends on wap_pkg
`timescale 1ns / 1ps

interface wap_req_if #(
    parameter int WORD_BITS = wap_pkg::WORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [wap_pkg::OP_BITS-1:0]   req_type;
    logic [WORD_BITS-1:0]          operand_a;
    logic [WORD_BITS-1:0]          operand_b;

    modport source (output valid, output req_type, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input req_type, input operand_a, input operand_b,
                    output ready);
endinterface

interface wap_rsp_if #(
    parameter int WORD_BITS = wap_pkg::WORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] result_word;
    logic                 op_status;

    modport source (output valid, output result_word, output op_status, input ready);
    modport sink   (input valid, input result_word, input op_status, output ready);
endinterface

// ----- hdl/wap_mul.sv -----
// wap_mul: shift-add multiplier, one multiplier bit per cycle, low word kept
// depends on wap_pkg for the default width
`timescale 1ns / 1ps

module wap_mul #(
    parameter int WORD_BITS = wap_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_x,
    input  logic [WORD_BITS-1:0] i_y,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_prod
);

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORD_BITS - 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WORD_BITS-1:0] r_x, n_x;
    logic [WORD_BITS-1:0] r_y, n_y;
    logic [WORD_BITS-1:0] r_p, n_p;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_p    = r_p;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = LAST_CNT;
            n_x    = i_x;
            n_y    = i_y;
            n_p    = '0;
        end else if (r_busy) begin
            n_p = r_p + (r_y[0] ? r_x : '0);
            n_x = {r_x[WORD_BITS-2:0], 1'b0};
            n_y = {1'b0, r_y[WORD_BITS-1:1]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_y   <= n_y;
        r_p   <= n_p;
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

// ----- hdl/word_alu_with_power.sv -----
// word alu with power: one item at a time, W = WORD_BITS; add, sub and logic ops run
// bit-serially, div and rem through the divider, mul through the shift-add unit,
// divide by zero and undefined opcodes go straight to done, pow by square-and-multiply
// input is ready again in the cycle after the result loads; a finished result waits
// in the done state while the output register is still full
// synchronous active-low reset clears the sequencer and the output valid
`timescale 1ns / 1ps

module word_alu_with_power #(
    parameter int WORD_BITS = wap_pkg::WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wap_req_if.sink   i_req,
    wap_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORD_BITS - 1);

    wap_pkg::t_state r_state, n_state;

    logic [wap_pkg::OP_BITS-1:0] r_op, n_op;
    logic [WORD_BITS-1:0]        r_a, n_a;
    logic [WORD_BITS-1:0]        r_b, n_b;
    logic [WORD_BITS-1:0]        r_res, n_res;
    logic                        r_st, n_st;
    logic                        r_cy, n_cy;
    logic [CNT_W-1:0]            r_cnt, n_cnt;

    logic                        r_out_valid, n_out_valid;
    logic [WORD_BITS-1:0]        r_out_word, n_out_word;
    logic                        r_out_status, n_out_status;

    logic                        mul_start;
    logic [WORD_BITS-1:0]        mul_x, mul_y;
    logic                        mul_done;
    logic [WORD_BITS-1:0]        mul_prod;

    // bit-serial datapath
    logic b_in, ser_bit, ser_cy;
    // divider step
    logic [WORD_BITS:0]   div_trial;
    logic                 div_q;
    logic [WORD_BITS-1:0] div_rem;
    logic                 out_free;

    wap_mul #(
        .WORD_BITS(WORD_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_x    (mul_x),
        .i_y    (mul_y),
        .o_done (mul_done),
        .o_prod (mul_prod)
    );

    assign i_req.ready = (r_state == wap_pkg::S_IDLE);
    assign out_free    = !r_out_valid || o_rsp.ready;

    always_comb begin
        b_in    = r_b[0] ^ (r_op == wap_pkg::OP_SUB);
        ser_cy  = (r_a[0] & b_in) | (r_cy & (r_a[0] ^ b_in));
        ser_bit = 1'b0;
        unique case (r_op)
            wap_pkg::OP_ADD, wap_pkg::OP_SUB: ser_bit = r_a[0] ^ b_in ^ r_cy;
            wap_pkg::OP_XOR:                  ser_bit = r_a[0] ^ r_b[0];
            wap_pkg::OP_AND:                  ser_bit = r_a[0] & r_b[0];
            wap_pkg::OP_OR:                   ser_bit = r_a[0] | r_b[0];
            wap_pkg::OP_NOT:                  ser_bit = ~r_a[0];
            default:                          ser_bit = 1'b0;
        endcase
    end

    always_comb begin
        div_trial = {r_res, r_a[WORD_BITS-1]} - {1'b0, r_b};
        div_q     = ~div_trial[WORD_BITS];
        div_rem   = div_q ? div_trial[WORD_BITS-1:0]
                          : {r_res[WORD_BITS-2:0], r_a[WORD_BITS-1]};
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_a          = r_a;
        n_b          = r_b;
        n_res        = r_res;
        n_st         = r_st;
        n_cy         = r_cy;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_out_status = r_out_status;
        mul_start    = 1'b0;
        mul_x        = r_a;
        mul_y        = r_b;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            wap_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.req_type;
                    n_a     = i_req.operand_a;
                    n_b     = i_req.operand_b;
                    n_state = wap_pkg::S_DISPATCH;
                end
            end
            wap_pkg::S_DISPATCH: begin
                n_st  = wap_pkg::ST_OK;
                n_cnt = LAST_CNT;
                n_cy  = (r_op == wap_pkg::OP_SUB);
                n_res = '0;
                unique case (r_op)
                    wap_pkg::OP_ADD, wap_pkg::OP_SUB, wap_pkg::OP_XOR,
                    wap_pkg::OP_AND, wap_pkg::OP_OR, wap_pkg::OP_NOT: begin
                        n_state = wap_pkg::S_SERIAL;
                    end
                    wap_pkg::OP_MUL: begin
                        mul_start = 1'b1;
                        n_state   = wap_pkg::S_MUL;
                    end
                    wap_pkg::OP_DIV, wap_pkg::OP_REM: begin
                        if (r_b == '0) begin
                            n_st    = wap_pkg::ST_DIV0;
                            n_state = wap_pkg::S_DONE;
                        end else begin
                            n_state = wap_pkg::S_DIV;
                        end
                    end
                    wap_pkg::OP_POW: begin
                        // accumulator starts at one
                        n_res   = {{(WORD_BITS-1){1'b0}}, 1'b1};
                        n_state = wap_pkg::S_POW_CHK;
                    end
                    default: begin
                        n_state = wap_pkg::S_DONE;
                    end
                endcase
            end
            wap_pkg::S_SERIAL: begin
                n_a   = {1'b0, r_a[WORD_BITS-1:1]};
                n_b   = {1'b0, r_b[WORD_BITS-1:1]};
                n_res = {ser_bit, r_res[WORD_BITS-1:1]};
                n_cy  = ser_cy;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = wap_pkg::S_DONE;
                end
            end
            wap_pkg::S_DIV: begin
                // quotient shifts into r_a, partial remainder lives in r_res
                n_a   = {r_a[WORD_BITS-2:0], div_q};
                n_res = div_rem;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (r_op == wap_pkg::OP_DIV) begin
                        n_res = {r_a[WORD_BITS-2:0], div_q};
                    end
                    n_state = wap_pkg::S_DONE;
                end
            end
            wap_pkg::S_MUL: begin
                if (mul_done) begin
                    n_res   = mul_prod;
                    n_state = wap_pkg::S_DONE;
                end
            end
            wap_pkg::S_POW_CHK: begin
                // r_res = accumulator, r_a = base power, r_b = remaining exponent
                if (r_b == '0) begin
                    n_state = wap_pkg::S_DONE;
                end else if (r_b[0]) begin
                    mul_start = 1'b1;
                    mul_x     = r_res;
                    mul_y     = r_a;
                    n_state   = wap_pkg::S_POW_MUL;
                end else begin
                    mul_start = 1'b1;
                    mul_x     = r_a;
                    mul_y     = r_a;
                    n_state   = wap_pkg::S_POW_SQR;
                end
            end
            wap_pkg::S_POW_MUL: begin
                if (mul_done) begin
                    n_res = mul_prod;
                    if (r_b[WORD_BITS-1:1] == '0) begin
                        n_state = wap_pkg::S_DONE;
                    end else begin
                        mul_start = 1'b1;
                        mul_x     = r_a;
                        mul_y     = r_a;
                        n_state   = wap_pkg::S_POW_SQR;
                    end
                end
            end
            wap_pkg::S_POW_SQR: begin
                if (mul_done) begin
                    n_a     = mul_prod;
                    n_b     = {1'b0, r_b[WORD_BITS-1:1]};
                    n_state = wap_pkg::S_POW_CHK;
                end
            end
            wap_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_word   = r_res;
                    n_out_status = r_st;
                    n_state      = wap_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wap_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wap_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_a          <= n_a;
        r_b          <= n_b;
        r_res        <= n_res;
        r_st         <= n_st;
        r_cy         <= n_cy;
        r_cnt        <= n_cnt;
        r_out_word   <= n_out_word;
        r_out_status <= n_out_status;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_word = r_out_word;
    assign o_rsp.op_status   = r_out_status;

`ifndef SYNTHESIS
    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == wap_pkg::S_MUL || r_state == wap_pkg::S_POW_MUL ||
                      r_state == wap_pkg::S_POW_SQR))
        else $error("multiplier finished with no pass pending");

    a_div0_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wap_pkg::S_DONE && r_st) |->
            (r_op == wap_pkg::OP_DIV || r_op == wap_pkg::OP_REM))
        else $error("divide-by-zero status on a non-divide item");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wap_pkg::S_DIV) |-> (r_b != '0))
        else $error("divider running with zero divisor");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == wap_pkg::S_DISPATCH))
        else $error("accepted item not dispatched");

    a_pow_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wap_pkg::S_POW_SQR && mul_done) |=> (r_b == ($past(r_b) >> 1)))
        else $error("exponent not advanced after squaring");
`endif

endmodule

// ----- bench/word_alu_with_power_test.sv -----
// word_alu_with_power_test: self-checking bench for the word alu with power
// directed table then random items, both channels throttled; depends on wap_pkg, wap_ifs and word_alu_with_power
`timescale 1ns / 1ps

module word_alu_with_power_test;

    localparam int W             = wap_pkg::WORD_BITS_DEF;
    localparam int RANDOM_ITEMS  = 500;
    localparam int STEADY_FIRST  = 150;
    localparam int STEADY_LAST   = 249;
    localparam int IDLE_PERCENT  = 35;
    // slowest op is pow with all exponent bits set
    localparam int TAIL_CYCLES   = 2 * W * (W + 2) + 64;
    localparam int CYCLE_LIMIT   = 6_000_000;
    localparam int PRINT_LIMIT   = 20;

    localparam logic [wap_pkg::OP_BITS-1:0] OP_UNDEF_FIRST = 4'd10;
    localparam logic [wap_pkg::OP_BITS-1:0] OP_UNDEF_LAST  = 4'd15;
    localparam logic [W-1:0]                ALL_ONES       = '1;

    typedef struct packed {
        logic [W-1:0] word;
        logic         status;
    } t_alu_result;

    typedef struct packed {
        logic [wap_pkg::OP_BITS-1:0] op;
        logic [W-1:0]                a;
        logic [W-1:0]                b;
        logic                        typed;  // expected value typed in below
        logic [W-1:0]                word;
        logic                        status;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 25;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{wap_pkg::OP_ADD, ALL_ONES, 32'd1, 1'b1, 32'h0000_0000, wap_pkg::ST_OK},
        '{wap_pkg::OP_ADD, ALL_ONES, ALL_ONES, 1'b1, 32'hFFFF_FFFE, wap_pkg::ST_OK},
        '{wap_pkg::OP_SUB, 32'd0, 32'd1, 1'b1, 32'hFFFF_FFFF, wap_pkg::ST_OK},
        '{wap_pkg::OP_SUB, 32'd0, 32'd0, 1'b1, 32'h0000_0000, wap_pkg::ST_OK},
        '{wap_pkg::OP_MUL, ALL_ONES, ALL_ONES, 1'b1, 32'h0000_0001, wap_pkg::ST_OK},
        '{wap_pkg::OP_MUL, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0, wap_pkg::ST_OK},
        '{wap_pkg::OP_DIV, ALL_ONES, 32'd0, 1'b1, 32'h0000_0000, wap_pkg::ST_DIV0},
        '{wap_pkg::OP_REM, ALL_ONES, 32'd0, 1'b1, 32'h0000_0000, wap_pkg::ST_DIV0},
        '{wap_pkg::OP_DIV, ALL_ONES, 32'd1, 1'b1, 32'hFFFF_FFFF, wap_pkg::ST_OK},
        '{wap_pkg::OP_DIV, 32'd0, ALL_ONES, 1'b1, 32'h0000_0000, wap_pkg::ST_OK},
        '{wap_pkg::OP_REM, ALL_ONES, ALL_ONES, 1'b1, 32'h0000_0000, wap_pkg::ST_OK},
        '{wap_pkg::OP_DIV, 32'd1000, 32'd7, 1'b0, 32'h0, wap_pkg::ST_OK},
        '{wap_pkg::OP_REM, 32'd1000, 32'd7, 1'b0, 32'h0, wap_pkg::ST_OK},
        '{wap_pkg::OP_POW, 32'd0, 32'd0, 1'b1, 32'h0000_0001, wap_pkg::ST_OK},
        '{wap_pkg::OP_POW, ALL_ONES, 32'd0, 1'b1, 32'h0000_0001, wap_pkg::ST_OK},
        '{wap_pkg::OP_POW, 32'd3, 32'd5, 1'b0, 32'h0, wap_pkg::ST_OK},
        '{wap_pkg::OP_POW, ALL_ONES, ALL_ONES, 1'b0, 32'h0, wap_pkg::ST_OK},
        '{wap_pkg::OP_POW, 32'd0, ALL_ONES, 1'b1, 32'h0000_0000, wap_pkg::ST_OK},
        '{wap_pkg::OP_XOR, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'hFFFF_FFFF, wap_pkg::ST_OK},
        '{wap_pkg::OP_AND, ALL_ONES, 32'd0, 1'b1, 32'h0000_0000, wap_pkg::ST_OK},
        '{wap_pkg::OP_OR, 32'd0, ALL_ONES, 1'b1, 32'hFFFF_FFFF, wap_pkg::ST_OK},
        '{wap_pkg::OP_NOT, 32'd0, ALL_ONES, 1'b1, 32'hFFFF_FFFF, wap_pkg::ST_OK},
        '{wap_pkg::OP_NOT, ALL_ONES, 32'd0, 1'b1, 32'h0000_0000, wap_pkg::ST_OK},
        '{OP_UNDEF_FIRST, ALL_ONES, ALL_ONES, 1'b1, 32'h0000_0000, wap_pkg::ST_OK},
        '{OP_UNDEF_LAST, ALL_ONES, ALL_ONES, 1'b1, 32'h0000_0000, wap_pkg::ST_OK}
    };

    logic i_clk;
    logic i_rst_n;

    wap_req_if #(.WORD_BITS(W)) req_ch ();
    wap_rsp_if #(.WORD_BITS(W)) rsp_ch ();

    word_alu_with_power #(.WORD_BITS(W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_alu_result pending_results [$];
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          items_sent     = 0;
    int          pow_items      = 0;
    int          div0_items     = 0;
    int          undef_items    = 0;
    int          cycle_count    = 0;
    bit          steady         = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // a^b mod 2^W by square-and-multiply over every exponent bit
    function automatic logic [W-1:0] power_wrapped(input logic [W-1:0] base,
                                                   input logic [W-1:0] expo);
        logic [W-1:0] acc;
        logic [W-1:0] sq;
        acc = W'(1);
        sq  = base;
        for (int i = 0; i < W; i++) begin
            if (expo[i]) acc = acc * sq;
            sq = sq * sq;
        end
        return acc;
    endfunction

    function automatic t_alu_result compute_word_result(
        input logic [wap_pkg::OP_BITS-1:0] op,
        input logic [W-1:0] a,
        input logic [W-1:0] b);
        t_alu_result r;
        r.word   = '0;
        r.status = wap_pkg::ST_OK;
        case (op)
            wap_pkg::OP_ADD: r.word = a + b;
            wap_pkg::OP_SUB: r.word = a - b;
            wap_pkg::OP_MUL: r.word = a * b;
            wap_pkg::OP_DIV: begin
                if (b == '0) r.status = wap_pkg::ST_DIV0;
                else r.word = a / b;
            end
            wap_pkg::OP_REM: begin
                if (b == '0) r.status = wap_pkg::ST_DIV0;
                else r.word = a % b;
            end
            wap_pkg::OP_POW: r.word = power_wrapped(a, b);
            wap_pkg::OP_XOR: r.word = a ^ b;
            wap_pkg::OP_AND: r.word = a & b;
            wap_pkg::OP_OR:  r.word = a | b;
            wap_pkg::OP_NOT: r.word = ~a;
            default: r.word = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s, got %h expected %h",
                     results_seen, what, got, want);
    endtask

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(9))
            0: return '0;
            1: return ALL_ONES;
            2: return W'($urandom_range(15));
            3: return W'(1) << $urandom_range(W - 1);
            4: return ALL_ONES ^ (W'(1) << $urandom_range(W - 1));
            default: return W'($urandom);
        endcase
    endfunction

    // drive one item and hold it until the handshake, then queue its expectation
    task automatic send_item(input logic [wap_pkg::OP_BITS-1:0] op, input logic [W-1:0] a,
                             input logic [W-1:0] b, input bit typed,
                             input t_alu_result typed_result);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(typed ? typed_result : compute_word_result(op, a, b));
        items_sent++;
        if (op == wap_pkg::OP_POW) pow_items++;
        if ((op == wap_pkg::OP_DIV || op == wap_pkg::OP_REM) && b == '0) div0_items++;
        if (op >= OP_UNDEF_FIRST) undef_items++;
    endtask

    // result side: check at the edge, then pick ready for the next cycle
    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", rsp_ch.result_word, '0);
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.result_word !== want.word)
                    report_mismatch("result_word", rsp_ch.result_word, want.word);
                if (rsp_ch.op_status !== want.status)
                    report_mismatch("op_status", W'(rsp_ch.op_status), W'(want.status));
            end
            results_seen++;
        end
        rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, pending_results.size());
        $display("word_alu_with_power_test NOT OK");
        $finish;
    end

    initial begin
        logic [wap_pkg::OP_BITS-1:0] op;
        logic [W-1:0]                a;
        logic [W-1:0]                b;
        t_alu_result                 typed_result;

        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= wap_pkg::OP_ADD;
        req_ch.operand_a <= '0;
        req_ch.operand_b <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            typed_result.word   = directed_rows[i].word;
            typed_result.status = directed_rows[i].status;
            send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].typed, typed_result);
        end

        typed_result = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= STEADY_FIRST && n <= STEADY_LAST);
            if ($urandom_range(99) < 6)
                op = wap_pkg::OP_BITS'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
            else
                op = wap_pkg::OP_BITS'($urandom_range(wap_pkg::OP_ADD, wap_pkg::OP_NOT));
            a = pick_operand();
            b = pick_operand();
            send_item(op, a, b, 1'b0, typed_result);
        end
        steady = 1'b0;
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", W'(pending_results.size()), '0);

        $display("sent %0d items (%0d directed), checked %0d results in %0d cycles",
                 items_sent, DIRECTED_ROWS, results_seen, cycle_count);
        $display("among them %0d pow, %0d divide by zero, %0d undefined opcodes; %0d mismatches",
                 pow_items, div0_items, undef_items, mismatch_count);
        if (mismatch_count == 0) begin
            $display("word_alu_with_power_test OK");
        end else begin
            $display("word_alu_with_power_test NOT OK");
        end
        $finish;
    end

endmodule
